// ----- rtl/zrd_pkg.sv -----
// Shared types, constants and register codes of the zero-run detector.
package zrd_pkg;

    localparam int ARITH_W        = 64;
    localparam int OFFSET_BITS    = 48;
    localparam int MAX_GROUP_LIST = 15;
    localparam int FIFO_DEPTH     = 4;
    localparam int CFG_DATA_W     = 48;
    localparam int CFG_IDX_W      = 2;

    localparam logic [47:0] MIN_RUN_RESET  = 48'd100;
    localparam logic [31:0] BLOCK_RESET    = 32'd4096;
    localparam logic [7:0]  ZERO_BYTE      = 8'd0;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_RUN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET      = 2'd3;

    localparam logic [1:0] KIND_REGION = 2'd0;
    localparam logic [1:0] KIND_GROUP  = 2'd1;
    localparam logic [1:0] KIND_QUIET  = 2'd2;

    localparam logic [1:0] CLS_HEADER   = 2'd0;
    localparam logic [1:0] CLS_BOUNDARY = 2'd1;
    localparam logic [1:0] CLS_MID      = 2'd2;
    localparam logic [1:0] CLS_NONE     = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_item;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [47:0] run_start;
        logic [47:0] run_length;
        logic [47:0] group_number;
        logic [31:0] group_block;
        logic [47:0] group_byte_offset;
        logic [1:0]  position_class;
        logic [2:0]  header_blocks_covered;
        logic        list_truncated;
        logic        last_of_report;
    } t_result;

    typedef struct packed {
        logic [ARITH_W-1:0] start;
        logic [ARITH_W-1:0] len;
    } t_run;

endpackage

// ----- rtl/zrd_if.sv -----
// Valid/ready channel carrying one payload of a given type.
interface zrd_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/zrd_front.sv -----
// Front end: tracks offsets and zero runs, queues each qualifying run.
module zrd_front import zrd_pkg::*; #(
    parameter int OFFSET_W = OFFSET_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    zrd_if.sink          i_in,
    input  logic [47:0]  i_min_run,
    input  logic         i_quiet,
    input  logic         i_full,
    output logic         o_push,
    output t_run         o_run
);
    logic [OFFSET_W-1:0] r_off, n_off, r_start, n_start, off_inc, len1, len2, start_mid;
    logic                r_in_run, n_in_run, r_stopped, n_stopped, accept, mid_run;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;
    assign off_inc    = r_off + OFFSET_W'(1);
    assign len1       = r_off - r_start;

    always_comb begin
        n_off     = r_off;
        n_start   = r_start;
        n_in_run  = r_in_run;
        n_stopped = r_stopped;
        o_push    = 1'b0;
        o_run     = '0;
        mid_run   = r_in_run;
        start_mid = r_start;
        len2      = '0;
        if (accept) begin
            if (!r_stopped) begin
                if (i_in.data.data_byte == ZERO_BYTE) begin
                    if (!r_in_run) begin
                        mid_run   = 1'b1;
                        start_mid = r_off;
                    end
                end else if (r_in_run) begin
                    mid_run = 1'b0;
                    if (ARITH_W'(len1) >= ARITH_W'(i_min_run)) begin
                        o_push    = 1'b1;
                        o_run.start = ARITH_W'(r_start);
                        o_run.len   = ARITH_W'(len1);
                    end
                end
                len2 = off_inc - start_mid;
                if (i_in.data.stream_end && mid_run) begin
                    mid_run = 1'b0;
                    if (ARITH_W'(len2) >= ARITH_W'(i_min_run)) begin
                        o_push      = 1'b1;
                        o_run.start = ARITH_W'(start_mid);
                        o_run.len   = ARITH_W'(len2);
                    end
                end
                n_off    = off_inc;
                n_start  = start_mid;
                n_in_run = mid_run;
                if (o_push && i_quiet) begin
                    n_stopped = 1'b1;
                end
            end
            if (i_in.data.stream_end) begin
                n_off     = '0;
                n_start   = '0;
                n_in_run  = 1'b0;
                n_stopped = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off     <= '0;
            r_start   <= '0;
            r_in_run  <= 1'b0;
            r_stopped <= 1'b0;
        end else begin
            r_off     <= n_off;
            r_start   <= n_start;
            r_in_run  <= n_in_run;
            r_stopped <= n_stopped;
        end
    end
endmodule

// ----- rtl/zrd_fifo.sv -----
// Short register queue of pending runs between front and back end.
module zrd_fifo import zrd_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_run i_data,
    input  logic i_pop,
    output t_run o_data,
    output logic o_empty,
    output logic o_full
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_run          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end
endmodule

// ----- rtl/zrd_div.sv -----
// Restoring divider, one quotient bit per cycle.
module zrd_div import zrd_pkg::*; #(
    parameter int W = ARITH_W
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_rem, r_quo, r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done, ge;
    logic [W:0]    shifted, diff;

    assign shifted = {r_rem, r_quo[W-1]};
    assign ge      = shifted >= {1'b0, r_div};
    assign diff    = shifted - {1'b0, r_div};
    assign o_done  = r_done;
    assign o_quo   = r_quo;
    assign o_rem   = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[W-1:0] : shifted[W-1:0];
            r_quo <= {r_quo[W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end
endmodule

// ----- rtl/zrd_back.sv -----
// Back end: annotates one queued run and emits its result items.
module zrd_back import zrd_pkg::*; #(
    parameter int MAX_GROUPS = MAX_GROUP_LIST
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_run        i_run,
    output logic        o_pop,
    input  logic [31:0] i_group_size,
    input  logic [31:0] i_block,
    input  logic        i_quiet,
    zrd_if.source       o_res
);
    localparam int CW = $clog2(MAX_GROUPS + 1);
    localparam logic [ARITH_W-1:0] ALL_ONES = '1;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV1, S_WAIT1, S_DIV2, S_WAIT2, S_COUNT, S_REP, S_ENTRY
    } t_state;

    t_state             r_state;
    logic [ARITH_W-1:0] r_start, r_len, r_gbytes, r_end, r_gnum, r_goff, r_cbase, r_ebase;
    logic [31:0]        r_gblk;
    logic [1:0]         r_cls;
    logic [CW-1:0]      r_cnt, r_idx;
    logic               r_trunc, r_ov;
    t_result            r_out;

    logic               div_start, div_done;
    logic [ARITH_W-1:0] div_a, div_b, div_q, div_r;
    logic [ARITH_W:0]   end_sum, next_sum;
    logic [ARITH_W-1:0] room;
    logic [33:0]        blk1, blk2, blk3;
    logic [2:0]         hdr;
    logic               list_end;
    t_result            rep_item, ent_item, short_item;

    assign div_start = (r_state == S_DIV1) || (r_state == S_DIV2);
    assign div_a     = (r_state == S_DIV1) ? r_start : r_goff;
    assign div_b     = (r_state == S_DIV1) ? r_gbytes : ARITH_W'(i_block);

    zrd_div #(.W(ARITH_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quo      (div_q),
        .o_rem      (div_r)
    );

    assign end_sum  = {1'b0, r_start} + {1'b0, r_len};
    assign next_sum = {1'b0, r_cbase} + {1'b0, r_gbytes};
    assign list_end = next_sum[ARITH_W] || (next_sum[ARITH_W-1:0] >= r_end);
    assign room     = r_end - r_ebase;
    assign blk1     = {2'b00, i_block};
    assign blk2     = {1'b0, i_block, 1'b0};
    assign blk3     = blk1 + blk2;
    assign hdr      = 3'(room != '0) + 3'(ARITH_W'(blk1) < room)
                    + 3'(ARITH_W'(blk2) < room) + 3'(ARITH_W'(blk3) < room);

    assign o_res.valid = r_ov;
    assign o_res.data  = r_out;
    assign o_pop       = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        rep_item                       = '0;
        rep_item.record_kind           = KIND_REGION;
        rep_item.run_start             = r_start[47:0];
        rep_item.run_length            = r_len[47:0];
        rep_item.group_number          = r_gnum[47:0];
        rep_item.group_block           = r_gblk;
        rep_item.group_byte_offset     = r_goff[47:0];
        rep_item.position_class        = r_cls;
        rep_item.list_truncated        = r_trunc || (!list_end && r_cnt == CW'(MAX_GROUPS));
        rep_item.last_of_report        = (r_cnt == '0);
        ent_item                       = '0;
        ent_item.record_kind           = KIND_GROUP;
        ent_item.run_start             = r_start[47:0];
        ent_item.run_length            = r_len[47:0];
        ent_item.group_number          = 48'(r_gnum + ARITH_W'(r_idx) + ARITH_W'(1));
        ent_item.position_class        = CLS_HEADER;
        ent_item.header_blocks_covered = hdr;
        ent_item.list_truncated        = r_trunc;
        ent_item.last_of_report        = (r_idx + CW'(1) == r_cnt);
        short_item                     = '0;
        short_item.record_kind         = i_quiet ? KIND_QUIET : KIND_REGION;
        short_item.run_start           = i_run.start[47:0];
        short_item.run_length          = i_run.len[47:0];
        short_item.position_class      = CLS_NONE;
        short_item.last_of_report      = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_start <= i_run.start;
                        r_len   <= i_run.len;
                        r_cnt   <= '0;
                        r_idx   <= '0;
                        r_trunc <= 1'b0;
                        if (i_quiet || i_group_size == '0 || i_block == '0) begin
                            r_out   <= short_item;
                            r_ov    <= 1'b1;
                            r_state <= S_REP;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_gbytes <= ARITH_W'(i_group_size) * ARITH_W'(i_block);
                    r_end    <= end_sum[ARITH_W] ? ALL_ONES : end_sum[ARITH_W-1:0];
                    r_state  <= S_DIV1;
                end
                S_DIV1: begin
                    r_state <= S_WAIT1;
                end
                S_WAIT1: begin
                    if (div_done) begin
                        r_gnum  <= div_q;
                        r_goff  <= div_r;
                        r_cbase <= r_start - div_r;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    r_state <= S_WAIT2;
                end
                S_WAIT2: begin
                    if (div_done) begin
                        r_gblk  <= div_q[31:0];
                        if (div_r != '0) begin
                            r_cls <= CLS_MID;
                        end else if (div_q <= ARITH_W'(3)) begin
                            r_cls <= CLS_HEADER;
                        end else begin
                            r_cls <= CLS_BOUNDARY;
                        end
                        r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    if (list_end) begin
                        r_state <= S_REP;
                        r_ov    <= 1'b1;
                        r_out   <= rep_item;
                    end else if (r_cnt == CW'(MAX_GROUPS)) begin
                        r_trunc <= 1'b1;
                        r_state <= S_REP;
                        r_ov    <= 1'b1;
                        r_out   <= rep_item;
                    end else begin
                        if (r_cnt == '0) begin
                            r_ebase <= next_sum[ARITH_W-1:0];
                        end
                        r_cbase <= next_sum[ARITH_W-1:0];
                        r_cnt   <= r_cnt + CW'(1);
                    end
                end
                S_REP: begin
                    if (o_res.ready) begin
                        if (r_cnt != '0) begin
                            r_out   <= ent_item;
                            r_idx   <= r_idx + CW'(1);
                            r_ebase <= r_ebase + r_gbytes;
                            r_state <= S_ENTRY;
                        end else begin
                            r_ov    <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ENTRY: begin
                    if (o_res.ready) begin
                        if (r_idx == r_cnt) begin
                            r_ov    <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_out   <= ent_item;
                            r_idx   <= r_idx + CW'(1);
                            r_ebase <= r_ebase + r_gbytes;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ov    <= 1'b0;
                end
            endcase
        end
    end
endmodule

// ----- rtl/zero_run_detector_with_group_annotation.sv -----
// Top level of the zero-run detector with allocation-group annotation.
//
// The block takes one byte per transfer on i_in and accepts a byte in every
// cycle while its run queue has room. Each zero run of at least
// min_run_length bytes goes into a four-entry queue, and the back end turns
// it into result transfers on o_res. A quiet-mode hit or an unannotated
// report goes straight from the idle state to the report state in the back
// end. An annotated report first runs two 64-bit divisions on one shared
// restoring divider, then counts the included groups of the group list one
// by one before the report appears; after that one result transfers per
// cycle while o_res is ready. The input stalls only when the queue holds
// four unserved runs.
// Configuration registers are written on the plain port (i_cfg_we, i_cfg_idx,
// i_cfg_data) and must only be changed while the block is idle.
module zero_run_detector_with_group_annotation import zrd_pkg::*; #(
    parameter int OFFSET_W   = OFFSET_BITS,
    parameter int MAX_GROUPS = MAX_GROUP_LIST
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    zrd_if.sink                   i_in,
    zrd_if.source                 o_res
);
    logic [47:0] r_min_run;
    logic [31:0] r_group_size;
    logic [31:0] r_block;
    logic        r_quiet;

    logic        push, pop, empty, full;
    t_run        push_run, head_run;

    // Configuration registers; the write carries the widest field, and the
    // narrower registers keep the low bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_run    <= MIN_RUN_RESET;
            r_group_size <= '0;
            r_block      <= BLOCK_RESET;
            r_quiet      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MIN_RUN:    r_min_run    <= i_cfg_data[47:0];
                REG_GROUP_SIZE: r_group_size <= i_cfg_data[31:0];
                REG_BLOCK:      r_block      <= i_cfg_data[31:0];
                REG_QUIET:      r_quiet      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The front end tracks the stream offset and the open run.
    zrd_front #(.OFFSET_W(OFFSET_W)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_min_run (r_min_run),
        .i_quiet   (r_quiet),
        .i_full    (full),
        .o_push    (push),
        .o_run     (push_run)
    );

    zrd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_run),
        .i_pop   (pop),
        .o_data  (head_run),
        .o_empty (empty),
        .o_full  (full)
    );

    // The back end locates each run in its group and lists later groups.
    zrd_back #(.MAX_GROUPS(MAX_GROUPS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_run        (head_run),
        .o_pop        (pop),
        .i_group_size (r_group_size),
        .i_block      (r_block),
        .i_quiet      (r_quiet),
        .o_res        (o_res)
    );

    // A quiet-mode hit is always a report of its own.
    a_quiet_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.record_kind == KIND_QUIET |-> o_res.data.last_of_report)
        else $error("quiet hit not marked as the last item");

    // Group entries always cover at least group block zero.
    a_entry_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.record_kind == KIND_GROUP |->
            o_res.data.header_blocks_covered != 3'd0 &&
            o_res.data.position_class == CLS_HEADER)
        else $error("group entry with no header blocks");

    // Truncation only happens in annotated reports.
    a_trunc_annot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.data.list_truncated |-> o_res.data.position_class != CLS_NONE)
        else $error("truncation flag on an unannotated item");
endmodule

// ----- tb/sv/zero_run_detector_with_group_annotation_test.sv -----
// Self-checking testbench of the zero-run detector with group annotation.
`timescale 1ns / 100ps

module zero_run_detector_with_group_annotation_test;
    import zrd_pkg::*;

    localparam int          CLK_HALF    = 5;
    localparam int          RESET_TICKS = 6;
    localparam int          DRAIN_TICKS = 300;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam logic [63:0] OFS_MASK    = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES    = ~64'd0;

    // One row of the directed table: either a register write or a byte that
    // is repeated count times, the last copy optionally marking stream end.
    // Where typed is set, the last copy yields exactly the result in want.
    typedef struct {
        bit              is_cfg;
        logic [1:0]      idx;
        logic [47:0]     value;
        logic [7:0]      data_byte;
        int unsigned     count;
        bit              fin;
        bit              typed;
        t_result         want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    zrd_if #(.T(t_item))   in_ch ();
    zrd_if #(.T(t_result)) res_ch ();

    zero_run_detector_with_group_annotation i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_res      (res_ch)
    );

    // Register copies held by the scanner model.
    logic [63:0] cfg_min_run;
    logic [63:0] cfg_group;
    logic [63:0] cfg_block;
    bit          cfg_quiet;

    // Scanner state: offset in the stream, open run, and quiet-mode halt.
    logic [63:0] scan_offset;
    bit          in_run;
    logic [63:0] run_origin;
    bit          halted;

    t_result step_results[$];
    t_result expected_results[$];
    t_row    directed_rows[$];

    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned gap_pct;
    int unsigned stall_pct;

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Builds the result items of one qualifying run into step_results.
    function automatic void emit_run(logic [63:0] st, logic [63:0] ln);
        t_result     r;
        logic [63:0] gbytes, gnum, goff, gblk, boff, run_end, base, room;
        logic [63:0] starts[$];
        int          cnt;
        bit          trunc;
        int unsigned hdr;
        r = '0;
        r.run_start  = st[47:0];
        r.run_length = ln[47:0];
        cnt = 0;
        trunc = 1'b0;
        if (cfg_quiet) begin
            r.record_kind    = KIND_QUIET;
            r.position_class = CLS_NONE;
            step_results.push_back(r);
            halted = 1'b1;
        end else if (cfg_group == 0 || cfg_block == 0) begin
            r.record_kind    = KIND_REGION;
            r.position_class = CLS_NONE;
            step_results.push_back(r);
        end else begin
            gbytes  = cfg_group * cfg_block;
            gnum    = st / gbytes;
            goff    = st % gbytes;
            gblk    = goff / cfg_block;
            boff    = goff % cfg_block;
            run_end = (ln > ALL_ONES - st) ? ALL_ONES : st + ln;
            base    = st - goff;
            // Collect the group starts that fall inside the run, up to the cap.
            while (1) begin
                if (gbytes > ALL_ONES - base) break;
                base += gbytes;
                if (base >= run_end) break;
                if (cnt == MAX_GROUP_LIST) begin
                    trunc = 1'b1;
                    break;
                end
                starts.push_back(base);
                cnt++;
            end
            r.record_kind       = KIND_REGION;
            r.group_number      = gnum[47:0];
            r.group_block       = gblk[31:0];
            r.group_byte_offset = goff[47:0];
            r.position_class    = (boff != 0) ? CLS_MID :
                                  ((gblk <= 3) ? CLS_HEADER : CLS_BOUNDARY);
            r.list_truncated    = trunc;
            step_results.push_back(r);
            for (int i = 0; i < cnt; i++) begin
                room = run_end - starts[i];
                hdr = 0;
                for (int b = 0; b <= 3; b++)
                    if (64'(b) * cfg_block < room) hdr++;
                r.record_kind           = KIND_GROUP;
                r.group_number          = 48'(gnum + 64'(i) + 64'd1);
                r.group_block           = '0;
                r.group_byte_offset     = '0;
                r.position_class        = CLS_HEADER;
                r.header_blocks_covered = 3'(hdr);
                step_results.push_back(r);
            end
        end
    endfunction

    // Advances the scanner by one byte and leaves its results in step_results.
    function automatic void scan_byte(logic [7:0] b, logic fin);
        logic [63:0] len;
        step_results = {};
        if (!halted) begin
            if (b == ZERO_BYTE) begin
                if (!in_run) begin
                    in_run     = 1'b1;
                    run_origin = scan_offset;
                end
            end else if (in_run) begin
                len    = (scan_offset - run_origin) & OFS_MASK;
                in_run = 1'b0;
                if (len >= cfg_min_run) emit_run(run_origin, len);
            end
            scan_offset = (scan_offset + 1) & OFS_MASK;
            // A stream end inside a run closes it after this byte is counted.
            if (fin && in_run) begin
                len    = (scan_offset - run_origin) & OFS_MASK;
                in_run = 1'b0;
                if (len >= cfg_min_run) emit_run(run_origin, len);
            end
        end
        if (fin) begin
            scan_offset = 0;
            in_run      = 1'b0;
            run_origin  = 0;
            halted      = 1'b0;
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last_of_report = 1'b1;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [47:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MIN_RUN:    cfg_min_run = 64'(value);
            REG_GROUP_SIZE: cfg_group   = 64'(value[31:0]);
            REG_BLOCK:      cfg_block   = 64'(value[31:0]);
            REG_QUIET:      cfg_quiet   = value[0];
            default: ;
        endcase
    endtask

    // Stops sending and lets the back end finish whatever it still holds.
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);
    endtask

    // Offers one byte, waits for its transfer, then records what it causes.
    task automatic send_byte(logic [7:0] b, logic fin, bit typed, t_result want);
        while ($urandom_range(99) < gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data.data_byte <= b;
        in_ch.data.stream_end <= fin;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        scan_byte(b, fin);
        if (typed) expected_results.push_back(want);
        else foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endtask

    function automatic t_result single_report(logic [1:0] kind, logic [47:0] st,
                                              logic [47:0] ln);
        t_result r;
        r = '0;
        r.record_kind    = kind;
        r.run_start      = st;
        r.run_length     = ln;
        r.position_class = CLS_NONE;
        r.last_of_report = 1'b1;
        return r;
    endfunction

    function automatic void add_cfg(logic [1:0] idx, logic [47:0] value);
        t_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.value  = value;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_bytes(logic [7:0] b, int unsigned count, bit fin,
                                      bit typed = 1'b0, t_result want = '0);
        t_row row;
        row = '{default: '0};
        row.data_byte = b;
        row.count     = count;
        row.fin       = fin;
        row.typed     = typed;
        row.want      = want;
        directed_rows.push_back(row);
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Receiver: stalls at the rate of the current phase.
    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Result monitor: every transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = res_ch.data;
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer, kind %0d start %0h",
                       got.record_kind, got.run_start);
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("record_kind", want.record_kind, got.record_kind);
                check_field("run_start", want.run_start, got.run_start);
                check_field("run_length", want.run_length, got.run_length);
                check_field("group_number", want.group_number, got.group_number);
                check_field("group_block", want.group_block, got.group_block);
                check_field("group_byte_offset", want.group_byte_offset,
                            got.group_byte_offset);
                check_field("position_class", want.position_class, got.position_class);
                check_field("header_blocks_covered", want.header_blocks_covered,
                            got.header_blocks_covered);
                check_field("list_truncated", want.list_truncated, got.list_truncated);
                check_field("last_of_report", want.last_of_report, got.last_of_report);
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned zeros_left;
        int unsigned pick;
        logic [7:0]  b;
        logic        fin;
        t_row        row;

        gap_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;

        cfg_min_run = 64'(MIN_RUN_RESET);
        cfg_group   = 0;
        cfg_block   = 64'(BLOCK_RESET);
        cfg_quiet   = 1'b0;
        scan_offset = 0;
        in_run      = 1'b0;
        run_origin  = 0;
        halted      = 1'b0;

        repeat (RESET_TICKS) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Each stream is closed before a typed row, so the
        // typed runs always start at offset zero.
        add_cfg(REG_MIN_RUN, 48'd2);
        add_bytes(8'h00, 2, 1'b0);
        add_bytes(8'h05, 1, 1'b1, 1'b1, single_report(KIND_REGION, 48'd0, 48'd2));
        // A run that the stream end closes, then one that is too short.
        add_bytes(8'h00, 2, 1'b1, 1'b1, single_report(KIND_REGION, 48'd0, 48'd2));
        add_bytes(8'h00, 1, 1'b1);
        // One-byte groups: a 17-byte run overflows the group list.
        add_cfg(REG_GROUP_SIZE, 48'd1);
        add_cfg(REG_BLOCK, 48'd1);
        add_bytes(8'h00, 17, 1'b0);
        add_bytes(8'h01, 1, 1'b1);
        // Run starting on a block boundary beyond the header blocks.
        add_cfg(REG_GROUP_SIZE, 48'd8);
        add_bytes(8'hFF, 5, 1'b0);
        add_bytes(8'h00, 2, 1'b0);
        add_bytes(8'h02, 1, 1'b1);
        // Zero block size turns annotation off.
        add_cfg(REG_BLOCK, 48'd0);
        add_bytes(8'h00, 3, 1'b1, 1'b1, single_report(KIND_REGION, 48'd0, 48'd3));
        // Largest group and block sizes.
        add_cfg(REG_GROUP_SIZE, 48'hFFFF_FFFF);
        add_cfg(REG_BLOCK, 48'hFFFF_FFFF);
        add_bytes(8'h00, 3, 1'b0);
        add_bytes(8'h01, 1, 1'b1);
        // Run starting mid-block.
        add_cfg(REG_GROUP_SIZE, 48'd2);
        add_cfg(REG_BLOCK, 48'd4096);
        add_bytes(8'h55, 1, 1'b0);
        add_bytes(8'h00, 3, 1'b1);
        // Quiet mode: one hit, the rest of the stream ignored, then a restart.
        add_cfg(REG_QUIET, 48'd1);
        add_bytes(8'h00, 2, 1'b0);
        add_bytes(8'h07, 1, 1'b0, 1'b1, single_report(KIND_QUIET, 48'd0, 48'd2));
        add_bytes(8'h00, 4, 1'b0);
        add_bytes(8'h09, 1, 1'b1);
        add_bytes(8'h00, 3, 1'b1, 1'b1, single_report(KIND_QUIET, 48'd0, 48'd3));
        // Largest threshold never fires; zero threshold fires on any run.
        add_cfg(REG_QUIET, 48'd0);
        add_cfg(REG_MIN_RUN, 48'hFFFF_FFFF_FFFF);
        add_bytes(8'h00, 4, 1'b0);
        add_bytes(8'hFF, 1, 1'b1);
        add_cfg(REG_MIN_RUN, 48'd0);
        add_bytes(8'h00, 1, 1'b0);
        add_bytes(8'h80, 1, 1'b1);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                wait_quiet();
                write_reg(row.idx, row.value);
            end else begin
                for (int unsigned k = 0; k < row.count; k++)
                    send_byte(row.data_byte, row.fin && k == row.count - 1,
                              row.typed && k == row.count - 1, row.want);
            end
        end

        // Random part: four idling phases, two register settings each.
        zeros_left = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 69; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 69; end
                default: begin gap_pct = 31; stall_pct = 31; end
            endcase
            for (int setting = 0; setting < 2; setting++) begin
                wait_quiet();
                // A stream end resets the scanner so the new setting starts clean.
                send_byte(8'h01, 1'b1, 1'b0, '0);
                wait_quiet();
                if ($urandom_range(7) == 0)
                    write_reg(REG_MIN_RUN, 48'({$urandom, $urandom}));
                else
                    write_reg(REG_MIN_RUN, 48'($urandom_range(0, 6)));
                pick = $urandom_range(0, 4);
                write_reg(REG_GROUP_SIZE, pick == 0 ? 48'd0 : pick == 1 ? 48'd1 :
                          pick == 2 ? 48'($urandom_range(2, 8)) :
                          pick == 3 ? 48'($urandom) : 48'd3);
                pick = $urandom_range(0, 3);
                write_reg(REG_BLOCK, pick == 0 ? 48'd1 :
                          pick == 1 ? 48'($urandom_range(1, 4)) :
                          pick == 2 ? 48'($urandom_range(1, 16)) : 48'($urandom));
                write_reg(REG_QUIET, 48'($urandom_range(0, 3) == 0));
                for (int n = 0; n < 50; n++) begin
                    if (phase == 2 && setting == 0 && n == 25) begin
                        // Hold the sender until the back end has caught up.
                        in_ch.valid <= 1'b0;
                        while (expected_results.size() != 0) @(posedge i_clk);
                    end
                    if ($urandom_range(9) == 0) begin
                        // Noise: any byte, any stream flag.
                        b   = 8'($urandom);
                        fin = 1'($urandom_range(1));
                    end else if (zeros_left > 0) begin
                        b   = ZERO_BYTE;
                        fin = ($urandom_range(24) == 0);
                        zeros_left--;
                    end else begin
                        b   = 8'($urandom_range(1, 255));
                        fin = ($urandom_range(29) == 0);
                        zeros_left = $urandom_range(0, 20);
                    end
                    send_byte(b, fin, 1'b0, '0);
                end
            end
        end

        wait_quiet();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/zrd_pkg.sv
rtl/zrd_if.sv
rtl/zrd_front.sv
rtl/zrd_fifo.sv
rtl/zrd_div.sv
rtl/zrd_back.sv
rtl/zero_run_detector_with_group_annotation.sv
tb/sv/zero_run_detector_with_group_annotation_test.sv
